>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/dvsm_pkg.sv
// ---------------------------------------------------------------------------
// dvsm_pkg
// Types and constants of the door valve sequence monitor.
// ---------------------------------------------------------------------------
`default_nettype none

package dvsm_pkg;

   localparam int TIME_BITS_DEF = 16;
   localparam int NOW_W         = 16;
   localparam int CFG_W         = 16;
   localparam int CSR_IDX_W     = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWITCH_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VALVE_SETTLE   = 2'd2;

   localparam logic [CFG_W-1:0] SWITCH_TIMEOUT_RST = 16'd3000;
   localparam logic [CFG_W-1:0] VALVE_SETTLE_RST   = 16'd500;

   localparam logic [1:0] PHASE_ARM    = 2'd0;
   localparam logic [1:0] PHASE_SWITCH = 2'd1;
   localparam logic [1:0] PHASE_VALVE  = 2'd2;
   localparam logic [1:0] PHASE_SPARE  = 2'd3;

   typedef struct packed {
      logic             door_input_low;
      logic             switch_low;
      logic             valve_low;
      logic             prevalve_low;
      logic             open_move_active;
      logic [NOW_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic switch_error;
      logic valve_error;
      logic prevalve_error;
      logic raise_alarm;
      logic any_error;
   } rsp_type;

   typedef struct packed {
      logic [1:0] phase;
      logic       switch_err;
      logic       valve_err;
      logic       prevalve_err;
   } flags_type;

   typedef struct packed {
      logic             enable;
      logic [CFG_W-1:0] switch_timeout_ms;
      logic [CFG_W-1:0] valve_settle_ms;
   } cfg_type;

endpackage

`default_nettype wire

>>> hw/rtl/dvsm_step.sv
// ---------------------------------------------------------------------------
// dvsm_step
// Next-state logic of the monitor for one sample.
// ---------------------------------------------------------------------------
`default_nettype none

module dvsm_step
   import dvsm_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  cfg_type              cfg,
   input  req_type              req,
   input  flags_type            cur,
   input  logic [TIME_BITS-1:0] start_cur,
   output flags_type            nxt,
   output logic [TIME_BITS-1:0] start_nxt,
   output logic                 alarm
);

   localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] elapsed;
   logic                 switch_late;
   logic                 valve_due;

   assign now_t       = TIME_BITS'(req.now_ms);
   assign elapsed     = now_t - start_cur;
   assign switch_late = CMP_W'(elapsed) >= CMP_W'(cfg.switch_timeout_ms);
   assign valve_due   = CMP_W'(elapsed) >= CMP_W'(cfg.valve_settle_ms);

   always_comb begin
      nxt       = cur;
      start_nxt = start_cur;
      alarm     = 1'b0;
      if (cfg.enable) begin
         if (req.door_input_low) begin
            unique case (cur.phase)
               PHASE_ARM: begin
                  nxt.phase = PHASE_SWITCH;
                  start_nxt = now_t;
               end
               PHASE_SWITCH: begin
                  if (req.switch_low) begin
                     if (switch_late) begin
                        nxt.switch_err = 1'b1;
                        alarm          = 1'b1;
                     end
                  end else begin
                     nxt.switch_err = 1'b0;
                     nxt.phase      = PHASE_VALVE;
                     start_nxt      = now_t;
                  end
               end
               PHASE_VALVE: begin
                  if (valve_due) begin
                     nxt.valve_err    = req.valve_low && !req.open_move_active;
                     nxt.prevalve_err = req.prevalve_low;
                     alarm = (req.valve_low && !req.open_move_active) || req.prevalve_low;
                  end
               end
               PHASE_SPARE: begin
                  nxt = cur;
               end
               default: begin
                  nxt = cur;
               end
            endcase
         end else begin
            nxt.phase        = PHASE_ARM;
            nxt.switch_err   = 1'b0;
            nxt.valve_err    = 1'b0;
            nxt.prevalve_err = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/door_valve_sequence_monitor_core.sv
// Path: an accepted req goes from the input register to the result register and rsp_valid;
// a stalled rsp holds it. Throughput: one item per cycle unless rsp stalls; the phase and
// error update is one pass of compare logic between the two registers.
// Reset: synchronous, active high; phase, start time and error flags clear,
// enable=1, switch timeout=3000 ms, valve settle=500 ms.
// ---------------------------------------------------------------------------
// door_valve_sequence_monitor_core
// Door valve sequence monitor with valid/ready channels and a CSR write port.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module door_valve_sequence_monitor_core
   import dvsm_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cfg_type              cfg_ff, cfg_in;
   logic                 in_valid_ff, in_valid_in;
   req_type              in_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   flags_type            flags_ff, flags_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic                 alarm;
   logic                 advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   dvsm_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .cfg       (cfg_ff),
      .req       (in_data_ff),
      .cur       (flags_ff),
      .start_cur (start_ff),
      .nxt       (flags_in),
      .start_nxt (start_in),
      .alarm     (alarm)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ENABLE:         cfg_in.enable            = csr_wdata[0];
            CSR_SWITCH_TIMEOUT: cfg_in.switch_timeout_ms = csr_wdata;
            CSR_VALVE_SETTLE:   cfg_in.valve_settle_ms   = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      rsp_data_in.switch_error   = flags_in.switch_err;
      rsp_data_in.valve_error    = flags_in.valve_err;
      rsp_data_in.prevalve_error = flags_in.prevalve_err;
      rsp_data_in.raise_alarm    = alarm;
      rsp_data_in.any_error      = flags_in.switch_err || flags_in.valve_err
                                   || flags_in.prevalve_err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable            <= 1'b1;
         cfg_ff.switch_timeout_ms <= SWITCH_TIMEOUT_RST;
         cfg_ff.valve_settle_ms   <= VALVE_SETTLE_RST;
         in_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         flags_ff.phase           <= PHASE_ARM;
         flags_ff.switch_err      <= 1'b0;
         flags_ff.valve_err       <= 1'b0;
         flags_ff.prevalve_err    <= 1'b0;
         start_ff                 <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            flags_ff <= flags_in;
            start_ff <= start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `ASSERT_ALWAYS(a_alarm_has_error, clock, reset,
      !rsp_valid_ff || !rsp_data_ff.raise_alarm || rsp_data_ff.any_error)
   `ASSERT_ALWAYS(a_no_spare_phase, clock, reset, flags_ff.phase != PHASE_SPARE)
   `ASSERT_NEXT(a_disabled_holds, clock, reset, advance && !cfg_ff.enable,
      $stable(flags_ff) && $stable(start_ff))
   `ASSERT_NEXT(a_no_alarm_disabled, clock, reset, advance && !cfg_ff.enable,
      !rsp_data_ff.raise_alarm)

endmodule

`default_nettype wire
